// ----- design/psal_pkg.sv -----
// ----------------------------------------------------------------------------
// psal_pkg
// Shared types, widths and codes for the pulse-synced stereo looper.
// ----------------------------------------------------------------------------
package psal_pkg;

	localparam int STORE_DEPTH = 131072;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SAMPLE_W    = 24;
	localparam int SPP_W       = 16;
	localparam int PPL_W       = 9;
	localparam int LEN_W       = 18;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 18;
	localparam int MODE_CODE_W = 3;
	localparam int CMP_W       = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_LOOP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH       = 2'd2;

	localparam logic [SPP_W-1:0] SPP_RESET = 16'd6000;
	localparam logic [PPL_W-1:0] PPL_RESET = 9'd16;
	localparam logic [LEN_W-1:0] LEN_RESET = 18'd96000;

	// Looper mode codes as seen on the result stream.
	localparam logic [MODE_CODE_W-1:0] CODE_STANDBY    = 3'd0;
	localparam logic [MODE_CODE_W-1:0] CODE_PEND_REC   = 3'd1;
	localparam logic [MODE_CODE_W-1:0] CODE_RECORDING  = 3'd2;
	localparam logic [MODE_CODE_W-1:0] CODE_PLAYING    = 3'd3;
	localparam logic [MODE_CODE_W-1:0] CODE_PEND_CLEAR = 3'd4;

	// Input kinds carried in tuser.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_PRESS  = 1'b1;

	typedef enum logic [4:0] {
		MODE_STANDBY    = 5'b00001,
		MODE_PEND_REC   = 5'b00010,
		MODE_RECORDING  = 5'b00100,
		MODE_PLAYING    = 5'b01000,
		MODE_PEND_CLEAR = 5'b10000
	} mode_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	function automatic logic [MODE_CODE_W-1:0] mode_code(mode_t m);
		logic [MODE_CODE_W-1:0] c;
		unique case (m)
			MODE_STANDBY:    c = CODE_STANDBY;
			MODE_PEND_REC:   c = CODE_PEND_REC;
			MODE_RECORDING:  c = CODE_RECORDING;
			MODE_PLAYING:    c = CODE_PLAYING;
			MODE_PEND_CLEAR: c = CODE_PEND_CLEAR;
			default:         c = CODE_STANDBY;
		endcase
		return c;
	endfunction

	// Adds two samples and clamps the result to the sample range.
	function automatic sample_t sat_add(sample_t a, sample_t b);
		logic signed [SAMPLE_W:0] s;
		sample_t r;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
			r = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			r = s[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- design/pulse_synced_audio_looper_top.sv -----
// ----------------------------------------------------------------------------
// pulse_synced_audio_looper_top
// A result passes through stage 1 and the result register before it appears.
// Throughput: one transaction per cycle unless the output stalls or a sweep
// runs; the store read and write-back use separate RAM ports, so consecutive
// samples never contend. Reset and each clear of the loop run a zeroing sweep
// over all 131072 store entries, one entry per cycle, with s_axis_tready low.
// ----------------------------------------------------------------------------
module pulse_synced_audio_looper_top
	import psal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [47:0]           s_axis_tdata,  // in_left[23:0], in_right[47:24]
	input  logic                  s_axis_tuser,  // command
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [55:0]           m_axis_tdata,  // out_left, out_right, looper_mode
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [SPP_W-1:0] spp_q;
	logic [PPL_W-1:0] ppl_q;
	logic [LEN_W-1:0] len_q;

	// Looper state
	mode_t             mode_q;
	logic [SPP_W-1:0]  tick_q;
	logic [PPL_W-1:0]  pulse_q;
	logic [ADDR_W-1:0] pos_q;

	// Zeroing sweep
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Stage 1: waiting on the store read
	logic                   valid_s1;
	logic                   press_s1;
	logic                   rec_s1;
	logic                   zero_s1;
	sample_t                hl_s1;
	sample_t                hr_s1;
	logic [MODE_CODE_W-1:0] code_s1;

	// Result register
	logic                   out_valid_q;
	sample_t                out_l_q;
	sample_t                out_r_q;
	logic [MODE_CODE_W-1:0] out_code_q;

	logic                   accept;
	logic                   is_press;
	logic                   s1_adv;
	logic [SPP_W-1:0]       spp_eff;
	logic [SPP_W:0]         tick_inc;
	logic                   tick;
	logic [PPL_W-1:0]       ppl_eff;
	logic                   boundary;
	logic [PPL_W-1:0]       pulse_next;
	mode_t                  mode_tick;
	mode_t                  mode_press;
	logic                   clear_evt;
	logic                   rec_now;
	logic [CMP_W-1:0]       len_eff;
	logic [CMP_W-1:0]       pos_inc;
	logic [ADDR_W-1:0]      pos_next;
	sample_t                hl;
	sample_t                hr;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [2*SAMPLE_W-1:0] ram_wdata;
	logic                  ram_re;
	logic [2*SAMPLE_W-1:0] ram_rdata;
	sample_t               st_l;
	sample_t               st_r;

	assign is_press      = (s_axis_tuser == CMD_PRESS);
	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !clr_q && (!valid_s1 || s1_adv);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Halving rounds toward minus infinity, which is an arithmetic shift.
	assign hl = sample_t'($signed(s_axis_tdata[SAMPLE_W-1:0]) >>> 1);
	assign hr = sample_t'($signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]) >>> 1);

	always_comb begin
		spp_eff  = (spp_q == '0) ? SPP_W'(1) : spp_q;
		tick_inc = {1'b0, tick_q} + (SPP_W+1)'(1);
		tick     = (tick_inc >= {1'b0, spp_eff});
		ppl_eff  = (ppl_q == '0) ? PPL_W'(1) : ppl_q;
		boundary = tick && !(pulse_q < ppl_eff);

		pulse_next = pulse_q;
		if (tick) begin
			pulse_next = boundary ? PPL_W'(1) : pulse_q + PPL_W'(1);
		end

		mode_tick = mode_q;
		if (boundary) begin
			unique case (mode_q)
				MODE_RECORDING:  mode_tick = MODE_PLAYING;
				MODE_PEND_REC:   mode_tick = MODE_RECORDING;
				MODE_PEND_CLEAR: mode_tick = MODE_STANDBY;
				default:         mode_tick = mode_q;
			endcase
		end
		clear_evt = boundary && (mode_q == MODE_PEND_CLEAR);
		rec_now   = (mode_tick == MODE_RECORDING);

		unique case (mode_q)
			MODE_PLAYING: mode_press = MODE_PEND_CLEAR;
			MODE_STANDBY: mode_press = MODE_PEND_REC;
			default:      mode_press = mode_q;
		endcase

		// Effective loop length is clamped to 1..STORE_DEPTH.
		len_eff = CMP_W'(len_q);
		if (len_eff == '0) begin
			len_eff = CMP_W'(1);
		end else if (len_eff > CMP_W'(STORE_DEPTH)) begin
			len_eff = CMP_W'(STORE_DEPTH);
		end
		pos_inc  = CMP_W'(pos_q) + CMP_W'(1);
		pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
	end

	// The write port serves the zeroing sweep or the recording write; the sweep
	// only runs while no transaction is accepted.
	always_comb begin
		ram_we    = clr_q || (accept && !is_press && rec_now);
		ram_waddr = clr_q ? clr_addr_q : pos_q;
		ram_wdata = clr_q ? '0 : {hr, hl};
		ram_re    = accept && !is_press;
	end

	psal_ram #(
		.WIDTH(2 * SAMPLE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q <= SPP_RESET;
			ppl_q <= PPL_RESET;
			len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SAMPLES_PER_PULSE: spp_q <= cfg_data[SPP_W-1:0];
				CFG_PULSES_PER_LOOP:   ppl_q <= cfg_data[PPL_W-1:0];
				CFG_LOOP_LENGTH:       len_q <= cfg_data[LEN_W-1:0];
				default:               ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STANDBY;
			tick_q  <= '0;
			pulse_q <= PPL_W'(1);
			pos_q   <= '0;
		end else if (accept) begin
			if (is_press) begin
				mode_q <= mode_press;
			end else begin
				mode_q  <= mode_tick;
				tick_q  <= tick ? '0 : tick_inc[SPP_W-1:0];
				pulse_q <= pulse_next;
				pos_q   <= pos_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end else if (accept && !is_press && clear_evt) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			press_s1 <= is_press;
			rec_s1   <= rec_now;
			zero_s1  <= clear_evt;
			hl_s1    <= hl;
			hr_s1    <= hr;
			code_s1  <= mode_code(is_press ? mode_press : mode_tick);
		end
	end

	// The stored value seen by a sample is the one just recorded, zero right
	// after a clear, or else the store read.
	always_comb begin
		priority if (rec_s1) begin
			st_l = hl_s1;
			st_r = hr_s1;
		end else if (zero_s1) begin
			st_l = '0;
			st_r = '0;
		end else begin
			st_l = ram_rdata[SAMPLE_W-1:0];
			st_r = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			out_l_q    <= press_s1 ? '0 : sat_add(st_l, hl_s1);
			out_r_q    <= press_s1 ? '0 : sat_add(st_r, hr_s1);
			out_code_q <= code_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_code_q, out_r_q, out_l_q};

`ifndef NO_ASSERTIONS
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !accept)
		else $error("transaction accepted during store sweep");

	a_sweep_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_press && clear_evt) |=> (clr_q && clr_addr_q == '0))
		else $error("clear did not start a store sweep");

	a_rec_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clr_q) |=> (mode_q == MODE_RECORDING))
		else $error("store written outside recording");

	a_s1_not_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> !accept)
		else $error("stage 1 overwritten while stalled");

	a_pulse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_q != '0)
		else $error("pulse index reached zero");
`endif

endmodule

// ----- design/psal_ram.sv -----
// ----------------------------------------------------------------------------
// psal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module psal_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
